// File: design/rgbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbe_pkg
// types, constants and helpers shared by the rgb emboss filter modules
// ----------------------------------------------------------------------------
package rgbe_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int CHAN_W      = 8;
	localparam int CNT_W       = 10;
	localparam int DIM_W       = 11;
	localparam int CFG_IDX_W   = 1;
	localparam int STORE_DEPTH = 2 * MAX_WIDTH + 2;
	localparam int PTR_W       = $clog2(STORE_DEPTH);
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
	localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);
	localparam logic [DIM_W-1:0] MIN_DIM      = DIM_W'(3);
	localparam logic [DIM_W-1:0] MAX_WIDTH_V  = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] MAX_HEIGHT_V = DIM_W'(MAX_HEIGHT);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan_c;
		logic [CHAN_W-1:0] chan_b;
		logic [CHAN_W-1:0] chan_a;
	} pix_t;

	typedef struct packed {
		logic [CHAN_W-1:0] emb_a;
		logic [CHAN_W-1:0] emb_b;
		logic [CHAN_W-1:0] emb_c;
		logic [CNT_W-1:0]  out_row;
		logic [CNT_W-1:0]  out_col;
		logic              frame_end;
	} res_t;

	typedef struct packed {
		pix_t             now;
		pix_t             old;
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
		logic             frame_end;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	localparam int PIX_W = $bits(pix_t);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v < MIN_DIM) begin
			r = MIN_DIM;
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: design/rgbe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbe_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rgbe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2050
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// File: design/rgbe_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbe_front
// accepts pixels, tracks position, runs the two-row delay line and
// classifies each pixel as interior centre or border
// ----------------------------------------------------------------------------
module rgbe_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire rgbe_pkg::cfg_idx_t             cfg_index,
	input  wire logic [rgbe_pkg::DIM_W-1:0]     cfg_data,
	input  wire logic                           pix_valid,
	output      logic                           pix_ready,
	input  wire rgbe_pkg::pix_t                 pix,
	input  wire logic [rgbe_pkg::QCNT_W-1:0]    q_count,
	output      rgbe_pkg::q_push_t              q_push
);

	logic [rgbe_pkg::CNT_W-1:0] w_last_q;
	logic [rgbe_pkg::CNT_W-1:0] h_last_q;
	logic [rgbe_pkg::PTR_W-1:0] ptr_last_q;
	logic [rgbe_pkg::CNT_W-1:0] col_q;
	logic [rgbe_pkg::CNT_W-1:0] row_q;
	logic [rgbe_pkg::PTR_W-1:0] wr_ptr_q;
	logic [rgbe_pkg::DIM_W-1:0] w_eff;
	logic [rgbe_pkg::DIM_W-1:0] h_eff;
	logic                       accept;
	logic                       interior;
	logic                       valid_s1;
	rgbe_pkg::pix_t             pix_s1;
	logic [rgbe_pkg::CNT_W-1:0] row_s1;
	logic [rgbe_pkg::CNT_W-1:0] col_s1;
	logic                       fe_s1;
	logic [rgbe_pkg::PIX_W-1:0] old_data;

	assign w_eff    = rgbe_pkg::clamp_dim(cfg_data, rgbe_pkg::MAX_WIDTH_V);
	assign h_eff    = rgbe_pkg::clamp_dim(cfg_data, rgbe_pkg::MAX_HEIGHT_V);
	assign pix_ready = !cfg_we
		&& (({1'b0, q_count} + (rgbe_pkg::QCNT_W + 1)'(valid_s1))
		< (rgbe_pkg::QCNT_W + 1)'(rgbe_pkg::QDEPTH));
	assign accept   = pix_valid && pix_ready;
	assign interior = (row_q >= rgbe_pkg::CNT_W'(2)) && (col_q >= rgbe_pkg::CNT_W'(2));

	// frame geometry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q   <= rgbe_pkg::CNT_W'(rgbe_pkg::RESET_WIDTH - 1'b1);
			h_last_q   <= rgbe_pkg::CNT_W'(rgbe_pkg::RESET_HEIGHT - 1'b1);
			ptr_last_q <= rgbe_pkg::PTR_W'({rgbe_pkg::RESET_WIDTH, 1'b1});
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgbe_pkg::CFG_IMAGE_WIDTH: begin
					w_last_q   <= rgbe_pkg::CNT_W'(w_eff - 1'b1);
					ptr_last_q <= rgbe_pkg::PTR_W'({w_eff, 1'b1});
				end
				rgbe_pkg::CFG_IMAGE_HEIGHT: begin
					h_last_q <= rgbe_pkg::CNT_W'(h_eff - 1'b1);
				end
				default: begin
				end
			endcase
		end
	end

	// position and delay line pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			wr_ptr_q <= '0;
		end else if (cfg_we) begin
			col_q    <= '0;
			row_q    <= '0;
			wr_ptr_q <= '0;
		end else if (accept) begin
			wr_ptr_q <= (wr_ptr_q == ptr_last_q) ? '0 : wr_ptr_q + 1'b1;
			if (col_q == w_last_q) begin
				col_q <= '0;
				row_q <= (row_q == h_last_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && interior;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix;
			row_s1 <= row_q - 1'b1;
			col_s1 <= col_q - 1'b1;
			fe_s1  <= (row_q == h_last_q) && (col_q == w_last_q);
		end
	end

	rgbe_ram #(
		.WIDTH(rgbe_pkg::PIX_W),
		.DEPTH(rgbe_pkg::STORE_DEPTH)
	) u_delay_ram (
		.clk    (clk),
		.we     (accept),
		.wr_addr(wr_ptr_q),
		.wr_data(pix),
		.rd_addr(wr_ptr_q),
		.rd_data(old_data)
	);

	always_comb begin
		q_push.valid           = valid_s1;
		q_push.entry.now       = pix_s1;
		q_push.entry.old       = rgbe_pkg::pix_t'(old_data);
		q_push.entry.row       = row_s1;
		q_push.entry.col       = col_s1;
		q_push.entry.frame_end = fe_s1;
	end

`ifndef NO_ASSERTIONS
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (col_q == '0) && (row_q == '0) && (wr_ptr_q == '0))
		else $error("frame not restarted after register write");
	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (row_s1 != '0) && (col_s1 != '0))
		else $error("border pixel classified as interior");
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q <= ptr_last_q)
		else $error("delay line pointer beyond line length");
`endif

endmodule
`default_nettype wire

// File: design/rgbe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbe_queue
// short fifo between the classifying front and the emboss back end
// ----------------------------------------------------------------------------
module rgbe_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rgbe_pkg::q_push_t           q_push,
	input  wire logic                        pop,
	output      rgbe_pkg::q_head_t           head,
	output      logic [rgbe_pkg::QCNT_W-1:0] count
);

	rgbe_pkg::q_entry_t          mem_q [rgbe_pkg::QDEPTH];
	logic [rgbe_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [rgbe_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [rgbe_pkg::QCNT_W-1:0] count_q;
	logic                        do_pop;

	assign do_pop = pop && (count_q != '0);
	assign count  = count_q;

	always_comb begin
		head.valid = count_q != '0;
		head.entry = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (q_push.valid) begin
			mem_q[wr_ptr_q] <= q_push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + rgbe_pkg::QCNT_W'(q_push.valid)
				- rgbe_pkg::QCNT_W'(do_pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.valid |-> (count_q != rgbe_pkg::QCNT_W'(rgbe_pkg::QDEPTH)))
		else $error("queue written while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rgbe_pkg::QCNT_W'(rgbe_pkg::QDEPTH))
		else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// File: design/rgbe_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgbe_back
// emboss arithmetic on the queue head and the result output register
// ----------------------------------------------------------------------------
module rgbe_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rgbe_pkg::q_head_t head,
	output      logic              pop,
	output      logic              res_valid,
	input  wire logic              res_ready,
	output      rgbe_pkg::res_t    res
);

	logic           res_valid_q;
	rgbe_pkg::res_t res_q;
	rgbe_pkg::res_t res_d;

	function automatic logic [rgbe_pkg::CHAN_W-1:0] emboss(
		input logic [rgbe_pkg::CHAN_W-1:0] now,
		input logic [rgbe_pkg::CHAN_W-1:0] old);
		logic signed [rgbe_pkg::CHAN_W+1:0] s;
		logic [rgbe_pkg::CHAN_W-1:0]        r;
		s = $signed({2'b00, now}) - $signed({2'b00, old})
			+ $signed((rgbe_pkg::CHAN_W + 2)'(128));
		if (s < 0) begin
			r = '0;
		end else if (s > $signed((rgbe_pkg::CHAN_W + 2)'(255))) begin
			r = '1;
		end else begin
			r = s[rgbe_pkg::CHAN_W-1:0];
		end
		return r;
	endfunction

	assign pop       = head.valid && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		res_d.emb_a     = emboss(head.entry.now.chan_a, head.entry.old.chan_a);
		res_d.emb_b     = emboss(head.entry.now.chan_b, head.entry.old.chan_b);
		res_d.emb_c     = emboss(head.entry.now.chan_c, head.entry.old.chan_c);
		res_d.out_row   = head.entry.row;
		res_d.out_col   = head.entry.col;
		res_d.frame_end = head.entry.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (pop) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_d;
		end
	end

endmodule
`default_nettype wire

// File: design/rgb_emboss_filter_3x3_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_emboss_filter_3x3_unit
// streaming 3x3 diagonal emboss on 24-bit rgb pixels in raster order
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while pix_ready is high (it drops on cfg_we
// or a near-full queue); the delay line ram does one read and one write at the
// same address per transfer; the output register can refill each cycle
// reset: counters, pointers and queue clear at once; geometry returns to
// 640 x 480; delay line contents are not cleared and need no clearing pass
module rgb_emboss_filter_3x3_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire rgbe_pkg::cfg_idx_t         cfg_index,
	input  wire logic [rgbe_pkg::DIM_W-1:0] cfg_data,
	input  wire logic                       pix_valid,
	output      logic                       pix_ready,
	input  wire rgbe_pkg::pix_t             pix,
	output      logic                       res_valid,
	input  wire logic                       res_ready,
	output      rgbe_pkg::res_t             res
);

	rgbe_pkg::q_push_t           q_push;
	rgbe_pkg::q_head_t           q_head;
	logic [rgbe_pkg::QCNT_W-1:0] q_count;
	logic                        q_pop;

	rgbe_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.pix      (pix),
		.q_count  (q_count),
		.q_push   (q_push)
	);

	rgbe_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.q_push(q_push),
		.pop   (q_pop),
		.head  (q_head),
		.count (q_count)
	);

	rgbe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.pop      (q_pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

endmodule
`default_nettype wire
